### hw/rtl/tida_pkg.sv
package tida_pkg;

	localparam int TagLen   = 10;
	localparam int HalfLen  = 5;
	localparam int FifoDepth = 4;
	localparam int FifoAw   = $clog2(FifoDepth);

	localparam logic [7:0] CharLow    = 8'd48;
	localparam logic [7:0] CharHigh   = 8'd90;
	localparam logic [7:0] HoldReset  = 8'd5;
	localparam logic [3:0] LastPos    = 4'(TagLen - 1);

	localparam logic CmdByte = 1'b0;
	localparam logic CmdTick = 1'b1;

	localparam logic [2:0] RegHoldTicks = 3'd0;

	typedef logic [TagLen-1:0][6:0] tag_t;

	typedef struct packed {
		logic is_tick;
		tag_t tag;
	} ev_t;

	function automatic logic [39:0] pack_half(tag_t t, int base);
		logic [39:0] h;
		h = '0;
		for (int i = 0; i < HalfLen; i++) begin
			h[39-8*i -: 8] = {1'b0, t[base+i]};
		end
		return h;
	endfunction

endpackage

### hw/rtl/tida_front.sv
module tida_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_fire,
	input  logic             cmd,
	input  logic [7:0]       rx_byte,
	output logic             push,
	output tida_pkg::ev_t    push_ev
);
	import tida_pkg::*;

	tag_t       buf_q;
	logic [3:0] pos_q;
	logic       is_char;

	assign is_char = (cmd == CmdByte) && (rx_byte >= CharLow) && (rx_byte <= CharHigh);

	always_ff @(posedge clk) begin
		if (in_fire && is_char) begin
			buf_q[pos_q] <= rx_byte[6:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (in_fire && is_char) begin
			pos_q <= (pos_q == LastPos) ? 4'd0 : pos_q + 4'd1;
		end
	end

	always_comb begin
		push_ev.is_tick = (cmd == CmdTick);
		push_ev.tag     = buf_q;
		push_ev.tag[TagLen-1] = rx_byte[6:0];
	end

	assign push = in_fire && ((cmd == CmdTick) || (is_char && pos_q == LastPos));

endmodule

### hw/rtl/tida_fifo.sv
module tida_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  tida_pkg::ev_t  push_ev,
	input  logic           pop,
	output tida_pkg::ev_t  head,
	output logic           empty,
	output logic           full
);
	import tida_pkg::*;

	ev_t                mem_q [FifoDepth];
	logic [FifoAw-1:0]  wr_q;
	logic [FifoAw-1:0]  rd_q;
	logic [FifoAw:0]    cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == (FifoAw+1)'(FifoDepth));
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_ev;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

### hw/rtl/tida_back.sv
module tida_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [7:0]     hold_ticks,
	input  tida_pkg::ev_t  head,
	input  logic           empty,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [79:0]    out_data
);
	import tida_pkg::*;

	tag_t        rem_q;
	logic        rem_valid_q;
	logic        hold_active_q;
	logic [7:0]  hold_count_q;
	logic        out_valid_q;
	logic [79:0] out_data_q;
	logic [7:0]  count_next;
	logic        is_new;

	assign pop        = !empty && (!out_valid_q || out_ready);
	assign count_next = hold_count_q + 8'd1;
	assign is_new     = !rem_valid_q || (head.tag != rem_q);
	assign out_valid  = out_valid_q;
	assign out_data   = out_data_q;

	always_ff @(posedge clk) begin
		if (pop && !head.is_tick && is_new) begin
			rem_q      <= head.tag;
			out_data_q <= {pack_half(head.tag, HalfLen), pack_half(head.tag, 0)};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_valid_q   <= 1'b0;
			hold_active_q <= 1'b0;
			hold_count_q  <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (pop && !head.is_tick && is_new) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				if (head.is_tick) begin
					if (hold_active_q) begin
						if (count_next >= hold_ticks) begin
							rem_valid_q   <= 1'b0;
							hold_active_q <= 1'b0;
							hold_count_q  <= '0;
						end else begin
							hold_count_q <= count_next;
						end
					end
				end else if (is_new) begin
					rem_valid_q <= 1'b1;
				end else if (!hold_active_q) begin
					hold_active_q <= 1'b1;
					hold_count_q  <= '0;
				end
			end
		end
	end

endmodule

### hw/rtl/tag_id_assembler_dedup.sv
// Tag ID assembler with repeat suppression.
// Input stream (s_axis_*): one transfer per event. tuser = cmd (0 = serial
// byte in tdata, 1 = one time tick). Bytes outside '0'..'Z' are dropped; the
// rest fill a ten-character tag. Each completed tag is reported on the output
// stream (m_axis_*) unless it repeats the remembered tag, in which case a hold
// timer starts; after hold_ticks ticks the remembered tag is forgotten.
// Output tdata: tag chars 0..4 in [39:0], chars 5..9 in [79:40], first char
// of each half in its top byte.
// The completing byte transfer is written into the event queue, then popped
// into the compare stage, whose output register drives m_axis_tvalid.
// Throughput: one input transfer per cycle; a four-entry event queue sits
// between the assembler and the compare/timer stage, so input keeps flowing
// while a result waits for m_axis_tready, until the queue fills.
// APB: hold_ticks at address 0 (reset 5); write only while idle.
// Reset (arst_n low) clears position, remembered tag, timer and output valid.
module tag_id_assembler_dedup (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	input  logic        s_axis_tuser,   // [0] cmd
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [79:0] m_axis_tdata    // [39:0] tag_first_half, [79:40] tag_second_half
);
	import tida_pkg::*;

	logic [7:0] hold_ticks_q;
	logic       in_fire;
	logic       push;
	ev_t        push_ev;
	ev_t        head;
	logic       pop;
	logic       empty;
	logic       full;

	assign pready = 1'b1;
	assign prdata = (paddr == RegHoldTicks) ? {24'd0, hold_ticks_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_ticks_q <= HoldReset;
		end else if (psel && penable && pwrite && paddr == RegHoldTicks) begin
			hold_ticks_q <= pwdata[7:0];
		end
	end

	assign s_axis_tready = !full;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	tida_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_fire (in_fire),
		.cmd     (s_axis_tuser),
		.rx_byte (s_axis_tdata),
		.push    (push),
		.push_ev (push_ev)
	);

	tida_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_ev (push_ev),
		.pop     (pop),
		.head    (head),
		.empty   (empty),
		.full    (full)
	);

	tida_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.hold_ticks (hold_ticks_q),
		.head       (head),
		.empty      (empty),
		.pop        (pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_data   (m_axis_tdata)
	);

endmodule

### tb/tag_dedup_checker.sv
module tag_dedup_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	input  logic        s_axis_tuser,   // [0] cmd
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [79:0] m_axis_tdata,   // [39:0] tag_first_half, [79:40] tag_second_half
	output int unsigned errors,
	output int unsigned pending
);
	import tida_pkg::*;

	localparam logic [2:0] HoldAddr = 3'(4 * RegHoldTicks);

	tag_t        char_buf;
	tag_t        last_tag;
	logic [3:0]  char_pos;
	logic        last_valid;
	logic        hold_on;
	logic [7:0]  hold_cnt;
	logic [7:0]  hold_limit;
	logic [79:0] tags_due[$];

	task automatic take_event(input logic cmd, input logic [7:0] data);
		logic [79:0] word;
		if (cmd == CmdTick) begin
			if (hold_on) begin
				hold_cnt = hold_cnt + 8'd1;
				if (hold_cnt >= hold_limit) begin
					last_valid = 1'b0;
					hold_on    = 1'b0;
					hold_cnt   = '0;
				end
			end
			return;
		end
		if (data < CharLow || data > CharHigh)
			return;
		char_buf[char_pos] = data[6:0];
		if (char_pos != LastPos) begin
			char_pos = char_pos + 4'd1;
			return;
		end
		char_pos = '0;
		if (!last_valid || char_buf != last_tag) begin
			last_tag   = char_buf;
			last_valid = 1'b1;
			word       = '0;
			for (int i = 0; i < HalfLen; i++) begin
				word[39-8*i -: 8] = {1'b0, char_buf[i]};
				word[79-8*i -: 8] = {1'b0, char_buf[HalfLen+i]};
			end
			tags_due.push_back(word);
		end else if (!hold_on) begin
			hold_on  = 1'b1;
			hold_cnt = '0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic [79:0] want;
		if (!arst_n) begin
			char_pos   = '0;
			last_valid = 1'b0;
			hold_on    = 1'b0;
			hold_cnt   = '0;
			hold_limit = HoldReset;
			errors     = 0;
			tags_due.delete();
		end else begin
			if (psel && penable && pwrite && pready && paddr == HoldAddr)
				hold_limit = pwdata[7:0];
			if (m_axis_tvalid && m_axis_tready) begin
				if (tags_due.size() == 0) begin
					errors++;
					$display("%0t: tag transfer with none expected, got %h", $time, m_axis_tdata);
				end else begin
					want = tags_due.pop_front();
					if (m_axis_tdata[39:0] !== want[39:0]) begin
						errors++;
						$display("%0t: tag_first_half expected %h got %h",
							$time, want[39:0], m_axis_tdata[39:0]);
					end
					if (m_axis_tdata[79:40] !== want[79:40]) begin
						errors++;
						$display("%0t: tag_second_half expected %h got %h",
							$time, want[79:40], m_axis_tdata[79:40]);
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				take_event(s_axis_tuser, s_axis_tdata);
		end
		pending = tags_due.size();
	end

endmodule

### tb/testbench.sv
module testbench;
	import tida_pkg::*;

	localparam logic [2:0] HoldAddr  = 3'(4 * RegHoldTicks);
	localparam logic [2:0] SpareAddr = 3'(4 * (RegHoldTicks + 3'd1));

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic        s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [79:0] m_axis_tdata;

	int unsigned errors;
	int unsigned pending;
	bit          steady;
	int unsigned counted;
	logic [7:0]  hold_now;
	tag_t        known_tags[4];

	tag_id_assembler_dedup u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	tag_dedup_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.pready        (pready),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.errors        (errors),
		.pending       (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("simulation failed");
		$finish;
	end

	always @(posedge clk) begin
		m_axis_tready <= steady || ($urandom_range(0, 99) >= 22);
	end

	function automatic logic [7:0] any_char();
		return 8'($urandom_range(CharLow, CharHigh));
	endfunction

	function automatic logic [7:0] junk_byte();
		if ($urandom_range(0, 1))
			return 8'($urandom_range(0, CharLow - 1));
		return 8'($urandom_range(CharHigh + 1, 255));
	endfunction

	function automatic tag_t fresh_tag();
		tag_t t;
		for (int i = 0; i < TagLen; i++)
			t[i] = 7'(any_char());
		return t;
	endfunction

	task automatic push_event(input logic cmd, input logic [7:0] data);
		while (!steady && $urandom_range(0, 99) < 22) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= data;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		if (cmd == CmdTick || (data >= CharLow && data <= CharHigh))
			counted++;
	endtask

	task automatic push_noise();
		if ($urandom_range(0, 2) == 0)
			push_event(CmdTick, 8'($urandom_range(0, 255)));
		else
			push_event(CmdByte, junk_byte());
	endtask

	task automatic push_tag(input tag_t t, input bit noisy);
		for (int i = 0; i < TagLen; i++) begin
			if (noisy && $urandom_range(0, 5) == 0)
				push_noise();
			push_event(CmdByte, {1'b0, t[i]});
		end
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic set_hold(input logic [7:0] v);
		apb_write(HoldAddr, {24'd0, v});
		hold_now = v;
	endtask

	task automatic run_phase(input int unsigned quota);
		int unsigned pick;
		int unsigned run_len;
		int unsigned keep;
		tag_t        t;
		counted = 0;
		while (counted < quota) begin
			pick = $urandom_range(0, 99);
			if ($urandom_range(0, 9) == 0)
				known_tags[2'($urandom_range(0, 3))] = fresh_tag();
			if (pick < 55) begin
				push_tag(known_tags[2'($urandom_range(0, 3))], $urandom_range(0, 99) < 15);
			end else if (pick < 70) begin
				// partial known tag finished with random characters
				t    = known_tags[2'($urandom_range(0, 3))];
				keep = $urandom_range(1, TagLen - 1);
				for (int i = keep; i < TagLen; i++)
					t[i] = 7'(any_char());
				push_tag(t, 1'($urandom_range(0, 1)));
			end else if (pick < 85) begin
				if ($urandom_range(0, 3) == 0)
					run_len = hold_now + $urandom_range(0, 1);
				else
					run_len = $urandom_range(1, 3);
				repeat (run_len) push_event(CmdTick, 8'($urandom_range(0, 255)));
			end else begin
				repeat ($urandom_range(1, 4)) push_noise();
			end
		end
	endtask

	initial begin
		tag_t edge_tag;
		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = CmdByte;
		steady        = 1'b0;
		hold_now      = HoldReset;
		for (int i = 0; i < 4; i++)
			known_tags[i] = fresh_tag();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// tick with no timer, bytes outside the character range (00, FF and each one just past its ends), extreme tag twice
		for (int i = 0; i < TagLen; i++)
			edge_tag[i] = (i % 2 == 0) ? CharLow[6:0] : CharHigh[6:0];
		push_event(CmdTick, 8'hFF);
		push_event(CmdByte, 8'h00);
		push_event(CmdByte, 8'hFF);
		push_event(CmdByte, CharLow - 8'd1);
		push_event(CmdByte, CharHigh + 8'd1);
		push_tag(edge_tag, 1'b0);
		push_tag(edge_tag, 1'b0);
		push_event(CmdTick, 8'h00);

		run_phase(160);
		drain();
		apb_write(SpareAddr, $urandom());
		set_hold(8'd1);
		run_phase(190);
		drain();
		set_hold(8'd255);
		run_phase(190);
		drain();
		steady = 1'b1;
		set_hold(8'd2);
		run_phase(190);
		drain();
		steady = 1'b0;
		set_hold(8'($urandom_range(3, 40)));
		run_phase(190);
		drain();

		if (errors == 0 && pending == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
